>>> sv/rpd_pkg.sv
`default_nettype none
package rpd_pkg;

    localparam int MAX_DIM = 256;
    localparam int DIM_CAP = (MAX_DIM > 256) ? 256 : ((MAX_DIM < 2) ? 2 : MAX_DIM);
    localparam logic [8:0] DIM_LIMIT = 9'(DIM_CAP);
    localparam logic [8:0] DIM_MIN = 9'd2;
    localparam logic [8:0] DIM_RESET = 9'd256;

    localparam int POS_W = 17;
    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam int DIV_STEPS = POS_W;
    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam int TARGET_W = POS_W + 1 + 9;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 4'd1;

    localparam logic [7:0] CH_LIVE = 8'h6F;
    localparam logic [7:0] CH_DEAD = 8'h62;
    localparam logic [7:0] CH_ROW = 8'h24;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_LIVE,
        OP_SKIP,
        OP_ROW,
        OP_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK,
        STS_OVERFLOW,
        STS_NO_LIVE,
        STS_ROWS
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ROW
    } t_state;

    function automatic logic [8:0] eff_dim(input logic [8:0] v);
        logic [8:0] r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > DIM_LIMIT) begin
            r = DIM_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/rpd_if.sv
`default_nettype none
interface rpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;
    modport source(output valid, output char_code, output end_of_text, input ready);
    modport sink(input valid, input char_code, input end_of_text, output ready);
endinterface

interface rpd_out_if;
    logic        valid;
    logic        ready;
    logic        is_status;
    logic [15:0] run_start;
    logic [16:0] run_length;
    logic [1:0]  status_code;
    modport source(output valid, output is_status, output run_start, output run_length,
                   output status_code, input ready);
    modport sink(input valid, input is_status, input run_start, input run_length,
                 input status_code, output ready);
endinterface

interface rpd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rpd_pkg::CFG_IDX_W-1:0]  index;
    logic [rpd_pkg::CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/rpd_front.sv
`default_nettype none
module rpd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rpd_in_if.sink             i_in,
    output rpd_pkg::t_cmd      o_push_cmd,
    output logic               o_push_valid,
    input  wire logic          i_push_ready
);

    logic          r_valid;
    logic          n_valid;
    rpd_pkg::t_cmd r_cmd;
    rpd_pkg::t_cmd n_cmd;
    rpd_pkg::t_cmd w_cmd;
    logic          w_keep;
    logic          w_accept;

    assign i_in.ready = !r_valid || i_push_ready;
    assign w_accept = i_in.valid && i_in.ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd = r_cmd;

    always_comb begin
        w_keep = 1'b1;
        w_cmd.op = rpd_pkg::OP_END;
        w_cmd.digit = 4'(i_in.char_code - rpd_pkg::CH_ZERO);
        if (i_in.end_of_text) begin
            w_cmd.op = rpd_pkg::OP_END;
        end else if (i_in.char_code >= rpd_pkg::CH_ZERO && i_in.char_code <= rpd_pkg::CH_NINE) begin
            w_cmd.op = rpd_pkg::OP_DIGIT;
        end else begin
            unique case (i_in.char_code)
                rpd_pkg::CH_LIVE: w_cmd.op = rpd_pkg::OP_LIVE;
                rpd_pkg::CH_DEAD: w_cmd.op = rpd_pkg::OP_SKIP;
                rpd_pkg::CH_ROW:  w_cmd.op = rpd_pkg::OP_ROW;
                default:          w_keep = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid && !i_push_ready;
        n_cmd = r_cmd;
        if (w_accept && w_keep) begin
            n_valid = 1'b1;
            n_cmd = w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

>>> sv/rpd_queue.sv
`default_nettype none
module rpd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rpd_pkg::t_cmd i_push_cmd,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    output rpd_pkg::t_cmd      o_pop_cmd,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready
);

    localparam logic [rpd_pkg::QPTR_W-1:0] LAST = rpd_pkg::QPTR_W'(rpd_pkg::QDEPTH - 1);
    localparam logic [rpd_pkg::QCNT_W-1:0] FULL = rpd_pkg::QCNT_W'(rpd_pkg::QDEPTH);

    rpd_pkg::t_cmd                r_mem [rpd_pkg::QDEPTH];
    logic [rpd_pkg::QPTR_W-1:0]   r_wr;
    logic [rpd_pkg::QPTR_W-1:0]   r_rd;
    logic [rpd_pkg::QCNT_W-1:0]   r_cnt;
    logic                         w_push;
    logic                         w_pop;

    assign o_push_ready = r_cnt != FULL;
    assign o_pop_valid = r_cnt != '0;
    assign o_pop_cmd = r_mem[r_rd];
    assign w_push = i_push_valid && o_push_ready;
    assign w_pop = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> sv/rpd_back.sv
`default_nettype none
module rpd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rpd_cfg_if.sink            i_cfg,
    input  wire rpd_pkg::t_cmd i_pop_cmd,
    input  wire logic          i_pop_valid,
    output logic               o_pop_ready,
    rpd_out_if.source          o_out
);

    localparam int PW = rpd_pkg::POS_W;
    localparam int CW = rpd_pkg::CNT_W;
    localparam int TW = rpd_pkg::TARGET_W;

    rpd_pkg::t_state           r_state, n_state;
    logic [8:0]                r_w, r_h;
    logic [PW-1:0]             r_total;
    logic [PW-1:0]             r_pos, n_pos;
    logic [CW-1:0]             r_repeat, n_repeat;
    logic                      r_count_present, n_count_present;
    logic [CW-1:0]             r_rows, n_rows;
    logic                      r_any_live, n_any_live;
    logic                      r_overflow, n_overflow;
    logic [CW-1:0]             r_mult, n_mult;
    logic [8:0]                r_rem, n_rem;
    logic [PW-1:0]             r_quo, n_quo;
    logic [rpd_pkg::STEP_W-1:0] r_step, n_step;
    logic [TW-1:0]             r_target, n_target;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_is_status, n_out_is_status;
    logic [15:0]               r_out_start, n_out_start;
    logic [16:0]               r_out_len, n_out_len;
    rpd_pkg::t_status          r_out_code, n_out_code;

    logic [CW-1:0]             w_mult;
    logic [CW+3:0]             w_digit_next;
    logic [PW:0]               w_run_end;
    logic [9:0]                w_trial;
    logic [PW:0]               w_row_sum;
    logic [CW:0]               w_rows_sum;
    logic                      w_cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr = i_cfg.valid;

    assign o_out.valid = r_out_valid;
    assign o_out.is_status = r_out_is_status;
    assign o_out.run_start = r_out_start;
    assign o_out.run_length = r_out_len;
    assign o_out.status_code = r_out_code;

    assign w_mult = r_count_present ? r_repeat : CW'(1);
    assign w_digit_next = {1'b0, r_repeat, 3'b000} + {3'b000, r_repeat, 1'b0}
                        + (CW+4)'(i_pop_cmd.digit);
    assign w_run_end = {1'b0, r_pos} + {1'b0, w_mult};
    assign w_trial = {r_rem, r_quo[PW-1]};
    assign w_row_sum = {1'b0, r_quo} + (PW+1)'(r_mult);
    assign w_rows_sum = {1'b0, r_rows} + {1'b0, r_mult};

    always_comb begin
        n_state = r_state;
        n_pos = r_pos;
        n_repeat = r_repeat;
        n_count_present = r_count_present;
        n_rows = r_rows;
        n_any_live = r_any_live;
        n_overflow = r_overflow;
        n_mult = r_mult;
        n_rem = r_rem;
        n_quo = r_quo;
        n_step = r_step;
        n_target = r_target;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_is_status = r_out_is_status;
        n_out_start = r_out_start;
        n_out_len = r_out_len;
        n_out_code = r_out_code;
        o_pop_ready = 1'b0;

        unique case (r_state)
            rpd_pkg::ST_IDLE: begin
                if (i_pop_valid && (!r_out_valid || o_out.ready)) begin
                    o_pop_ready = 1'b1;
                    if (i_pop_cmd.op == rpd_pkg::OP_END) begin
                        n_out_valid = 1'b1;
                        n_out_is_status = 1'b1;
                        n_out_start = '0;
                        n_out_len = '0;
                        if (r_overflow) begin
                            n_out_code = rpd_pkg::STS_OVERFLOW;
                        end else if (!r_any_live) begin
                            n_out_code = rpd_pkg::STS_NO_LIVE;
                        end else if (r_rows > CW'(r_h)) begin
                            n_out_code = rpd_pkg::STS_ROWS;
                        end else begin
                            n_out_code = rpd_pkg::STS_OK;
                        end
                        n_pos = '0;
                        n_repeat = '0;
                        n_count_present = 1'b0;
                        n_rows = '0;
                        n_any_live = 1'b0;
                        n_overflow = 1'b0;
                    end else if (!r_overflow) begin
                        case (i_pop_cmd.op) inside
                            rpd_pkg::OP_DIGIT: begin
                                n_count_present = 1'b1;
                                if (w_digit_next > (CW+4)'(rpd_pkg::COUNT_MAX)) begin
                                    n_repeat = rpd_pkg::COUNT_MAX;
                                end else begin
                                    n_repeat = w_digit_next[CW-1:0];
                                end
                            end
                            rpd_pkg::OP_ROW: begin
                                n_repeat = '0;
                                n_count_present = 1'b0;
                                n_mult = w_mult;
                                n_rem = '0;
                                n_quo = r_pos;
                                n_step = '0;
                                n_state = rpd_pkg::ST_DIV;
                            end
                            rpd_pkg::OP_LIVE, rpd_pkg::OP_SKIP: begin
                                n_repeat = '0;
                                n_count_present = 1'b0;
                                if (w_run_end > {1'b0, r_total}) begin
                                    n_overflow = 1'b1;
                                end else begin
                                    n_pos = w_run_end[PW-1:0];
                                    if (i_pop_cmd.op == rpd_pkg::OP_LIVE && w_mult != '0) begin
                                        n_any_live = 1'b1;
                                        n_out_valid = 1'b1;
                                        n_out_is_status = 1'b0;
                                        n_out_start = r_pos[15:0];
                                        n_out_len = w_mult;
                                        n_out_code = rpd_pkg::STS_OK;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            rpd_pkg::ST_DIV: begin
                if (w_trial >= {1'b0, r_w}) begin
                    n_rem = 9'(w_trial - {1'b0, r_w});
                    n_quo = {r_quo[PW-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[8:0];
                    n_quo = {r_quo[PW-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == rpd_pkg::STEP_W'(rpd_pkg::DIV_STEPS - 1)) begin
                    n_state = rpd_pkg::ST_MUL;
                end
            end
            rpd_pkg::ST_MUL: begin
                n_target = TW'(w_row_sum) * TW'(r_w);
                n_state = rpd_pkg::ST_ROW;
            end
            rpd_pkg::ST_ROW: begin
                if (r_target > TW'(r_total)) begin
                    n_overflow = 1'b1;
                end else begin
                    n_pos = r_target[PW-1:0];
                    n_rows = w_rows_sum[CW] ? rpd_pkg::COUNT_MAX : w_rows_sum[CW-1:0];
                end
                n_state = rpd_pkg::ST_IDLE;
            end
            default: begin
                n_state = rpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpd_pkg::ST_IDLE;
            r_w <= rpd_pkg::eff_dim(rpd_pkg::DIM_RESET);
            r_h <= rpd_pkg::eff_dim(rpd_pkg::DIM_RESET);
            r_total <= PW'(rpd_pkg::eff_dim(rpd_pkg::DIM_RESET))
                     * PW'(rpd_pkg::eff_dim(rpd_pkg::DIM_RESET));
            r_pos <= '0;
            r_repeat <= '0;
            r_count_present <= 1'b0;
            r_rows <= '0;
            r_any_live <= 1'b0;
            r_overflow <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr && i_cfg.index == rpd_pkg::REG_GRID_WIDTH) begin
                r_w <= rpd_pkg::eff_dim(i_cfg.data);
            end
            if (w_cfg_wr && i_cfg.index == rpd_pkg::REG_GRID_HEIGHT) begin
                r_h <= rpd_pkg::eff_dim(i_cfg.data);
            end
            r_total <= PW'(r_w) * PW'(r_h);
            r_pos <= n_pos;
            r_repeat <= n_repeat;
            r_count_present <= n_count_present;
            r_rows <= n_rows;
            r_any_live <= n_any_live;
            r_overflow <= n_overflow;
            r_out_valid <= n_out_valid;
        end
        r_mult <= n_mult;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_step <= n_step;
        r_target <= n_target;
        r_out_is_status <= n_out_is_status;
        r_out_start <= n_out_start;
        r_out_len <= n_out_len;
        r_out_code <= n_out_code;
    end

endmodule
`default_nettype wire

>>> sv/rle_pattern_run_decoder.sv
// Channel  Dir  Payload                                          Accepted when
// i_in     in   char_code[7:0], end_of_text                      valid && ready
// o_out    out  is_status, run_start[15:0], run_length[16:0],    valid && ready
//               status_code[1:0]
// i_cfg    in   index[3:0], data[8:0]                            valid && ready
//
// A digit, 'o', 'b' or end item is executed in the idle state of the executing stage;
// a '$' passes through the issue state, the 17-step restoring divider, a multiply
// state and a compare state. Other characters are dropped at the front.
// Reset is synchronous and active low and leaves a 256 by 256 grid.
// The front and the executing stage stall independently through a two-entry queue.
`default_nettype none
module rle_pattern_run_decoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rpd_in_if.sink    i_in,
    rpd_out_if.source o_out,
    rpd_cfg_if.sink   i_cfg
);

    rpd_pkg::t_cmd w_push_cmd;
    logic          w_push_valid;
    logic          w_push_ready;
    rpd_pkg::t_cmd w_pop_cmd;
    logic          w_pop_valid;
    logic          w_pop_ready;

    rpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_cmd   (w_push_cmd),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready)
    );

    rpd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cmd   (w_push_cmd),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .o_pop_cmd    (w_pop_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready)
    );

    rpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_pop_cmd   (w_pop_cmd),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
